// ===== src/circular_deque_defines.svh =====
// Assertion macros for the circular deque RTL.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define CDQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("circular_deque assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT_IMPL(label, ante, cons)
`define CDQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/cdq_pkg.sv =====
// Shared types and constants of the circular deque.
package cdq_pkg;

    localparam int OUT_W = 32;  // width of the value fields
    localparam int CAP_W = 11;  // width of the capacity register
    localparam int ACT_W = 3;   // width of the action field

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_NOP        = 3'd4
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

// ===== src/cdq_ram.sv =====
// Generic single-port RAM with a registered read, read-before-write.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                      i_wdata,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/circular_deque.sv =====
// Circular deque top level: a double-ended queue of words kept in a ring RAM.
// A push, a no-op, a refused request, or a pop that leaves at most one entry
// has its response registered straight from the request; a pop that leaves two
// or more entries first passes through the read state, for one RAM read.
// Throughput: one request per cycle unless responses back up; those pops stall it.
// Reset (synchronous, active low) empties the deque and sets capacity to STORE_DEPTH.
`include "circular_deque_defines.svh"

module circular_deque #(
    parameter int STORE_DEPTH = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port: capacity register.
    input  logic                       i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_wdata,
    // Request channel.
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic [cdq_pkg::ACT_W-1:0]  i_action,
    input  logic signed [cdq_pkg::OUT_W-1:0] i_value,
    // Response channel.
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_accepted,
    output logic signed [cdq_pkg::OUT_W-1:0] o_front_value,
    output logic signed [cdq_pkg::OUT_W-1:0] o_rear_value,
    output logic                       o_empty_res,
    output logic                       o_full_res
);

    import cdq_pkg::*;

    // Index width addresses the ring; count width holds the full depth.
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    // Architectural state. The front and rear words are cached in registers so
    // that only a pop which uncovers a new end entry needs a RAM read.
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cap, n_cap;
    logic [IDX_W-1:0]       r_head, n_head;
    logic [IDX_W-1:0]       r_tail, n_tail;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [OUT_W-1:0]       r_front, n_front;
    logic [OUT_W-1:0]       r_rear, n_rear;
    logic                   r_rd_front;

    // Response register.
    logic                   r_res_valid, n_res_valid;
    logic                   r_res_accepted;
    logic                   r_res_empty;
    logic                   r_res_full;

    // Request decode.
    logic                   w_req_fire;
    logic                   w_ok;
    logic                   w_we;
    logic                   w_read;
    logic                   w_rd_front;
    logic                   w_rd_done;
    logic [IDX_W-1:0]       w_addr;
    logic [IDX_W-1:0]       w_cap_m1;
    logic [WORD_BITS-1:0]   w_push_word;
    logic [WORD_BITS-1:0]   w_rdata;
    logic [OUT_W-1:0]       w_push_out;
    logic [OUT_W-1:0]       w_rd_out;

    // Word format. Stored words are WORD_BITS wide; the value ports always show
    // them sign-extended to, or cut down to, the 32-bit port width.
    generate
        if (WORD_BITS >= OUT_W) begin : g_wide_word
            assign w_push_word = WORD_BITS'($unsigned(i_value));
            assign w_push_out  = i_value;
            assign w_rd_out    = w_rdata[OUT_W-1:0];
        end else begin : g_narrow_word
            assign w_push_word = i_value[WORD_BITS-1:0];
            assign w_push_out  = OUT_W'($signed(w_push_word));
            assign w_rd_out    = OUT_W'($signed(w_rdata));
        end
    endgenerate

    // The last usable slot of the ring, one below the capacity.
    assign w_cap_m1 = IDX_W'(r_cap - CNT_W'(1));

    // Capacity write: zero acts as one, and anything above the store depth is
    // clamped to the depth.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(STORE_DEPTH)) begin
            n_cap = CNT_W'(STORE_DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_wdata);
        end
    end

    // Request decode: new pointers, new count, the RAM access, and the new
    // cached end words. A pop that leaves two or more entries must fetch the
    // newly exposed end word from the RAM; a pop that leaves one entry takes it
    // from the other cached end, because that entry is both front and rear.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_front    = r_front;
        n_rear     = r_rear;
        w_ok       = 1'b0;
        w_we       = 1'b0;
        w_read     = 1'b0;
        w_rd_front = 1'b0;
        w_addr     = r_head;
        unique case (t_action'(i_action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (r_cnt < r_cap) begin
                    w_ok  = 1'b1;
                    w_we  = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    priority if (r_cnt == '0) begin
                        // The first entry always lands in slot zero.
                        n_head  = '0;
                        n_tail  = '0;
                        w_addr  = '0;
                        n_front = w_push_out;
                        n_rear  = w_push_out;
                    end else if (t_action'(i_action) == ACT_PUSH_FRONT) begin
                        n_head  = (r_head == '0) ? w_cap_m1 : r_head - IDX_W'(1);
                        w_addr  = n_head;
                        n_front = w_push_out;
                    end else begin
                        n_tail  = (r_tail == w_cap_m1) ? '0 : r_tail + IDX_W'(1);
                        w_addr  = n_tail;
                        n_rear  = w_push_out;
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (r_cnt != '0) begin
                    w_ok  = 1'b1;
                    n_cnt = r_cnt - CNT_W'(1);
                    priority if (r_cnt == CNT_W'(1)) begin
                        // Popping the last entry returns both pointers home.
                        n_head = '0;
                        n_tail = '0;
                    end else if (t_action'(i_action) == ACT_POP_FRONT) begin
                        n_head = (r_head == w_cap_m1) ? '0 : r_head + IDX_W'(1);
                        w_addr = n_head;
                        if (r_cnt == CNT_W'(2)) begin
                            n_front = r_rear;
                        end else begin
                            w_read     = 1'b1;
                            w_rd_front = 1'b1;
                        end
                    end else begin
                        n_tail = (r_tail == '0) ? w_cap_m1 : r_tail - IDX_W'(1);
                        w_addr = n_tail;
                        if (r_cnt == CNT_W'(2)) begin
                            n_rear = r_front;
                        end else begin
                            w_read = 1'b1;
                        end
                    end
                end
            end
            ACT_NOP: begin
                w_ok = 1'b0;
            end
            default: begin
                // Unused action codes behave as a no-op.
                w_ok = 1'b0;
            end
        endcase
    end

    // Ring store. Reads and writes come from different request kinds and the
    // sequencer holds off new requests while a read is outstanding, so no two
    // accesses to the same entry overlap.
    cdq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we && w_req_fire),
        .i_addr  (w_addr),
        .i_wdata (w_push_word),
        .o_rdata (w_rdata)
    );

    // Sequencer next state: a pop that needs a RAM read passes through the read
    // state while waiting for the read data.
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = (w_req_fire && w_read) ? ST_READ : ST_IDLE;
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs. A new request is taken in the idle state whenever the
    // response register is free or is being emptied in the same cycle.
    always_comb begin
        o_req_ready = 1'b0;
        w_rd_done   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_req_ready = !r_res_valid || i_res_ready;
            ST_READ: w_rd_done   = 1'b1;
            default: o_req_ready = 1'b0;
        endcase
    end

    assign w_req_fire = i_req_valid && o_req_ready;

    // The response is ready at once, except for a pop that waits on the RAM.
    assign n_res_valid = (r_res_valid && !i_res_ready)
                       || (w_req_fire && !w_read)
                       || w_rd_done;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CNT_W'(STORE_DEPTH);
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                // A capacity write empties the deque.
                r_cap  <= n_cap;
                r_head <= '0;
                r_tail <= '0;
                r_cnt  <= '0;
            end else if (w_req_fire) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_cnt  <= n_cnt;
            end
        end
    end

    // Payload: cached end words and the response fields. The cached words feed
    // the value ports directly; they only change when the response register is
    // free or being emptied, so a pending response keeps its values.
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_front        <= n_front;
            r_rear         <= n_rear;
            r_rd_front     <= w_rd_front;
            r_res_accepted <= w_ok;
            r_res_empty    <= (n_cnt == '0);
            r_res_full     <= (n_cnt >= r_cap);
        end else if (w_rd_done) begin
            if (r_rd_front) begin
                r_front <= w_rd_out;
            end else begin
                r_rear <= w_rd_out;
            end
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_accepted    = r_res_accepted;
    assign o_empty_res   = r_res_empty;
    assign o_full_res    = r_res_full;
    assign o_front_value = r_res_empty ? '1 : r_front;
    assign o_rear_value  = r_res_empty ? '1 : r_rear;

    // The entry count never exceeds the effective capacity.
    `CDQ_ASSERT_IMPL(a_cnt_within_cap, 1'b1, r_cnt <= r_cap)
    // An empty deque keeps both pointers at slot zero.
    `CDQ_ASSERT_IMPL(a_empty_ptrs_home, r_cnt == '0, r_head == '0 && r_tail == '0)
    // While a RAM read is outstanding no new request is taken.
    `CDQ_ASSERT_IMPL(a_read_interlock, r_state == ST_READ, !o_req_ready)
    // A read always completes into a valid response on the following cycle.
    `CDQ_ASSERT_NEXT(a_read_gives_response, r_state == ST_READ, r_res_valid)

endmodule

// ===== verif/deque_tb_pkg.sv =====
// Response record and scoreboard class for the circular deque testbench.
`timescale 1ns / 100ps

package deque_tb_pkg;

    import cdq_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_REPORTS = 10;

    // Action codes that the block treats as no operation.
    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct {
        logic                    accepted;
        logic signed [OUT_W-1:0] front_value;
        logic signed [OUT_W-1:0] rear_value;
        logic                    empty;
        logic                    full;
    } t_deque_response;

    class t_deque_scoreboard;
        logic signed [OUT_W-1:0] ring [STORE_DEPTH];
        int unsigned             head;
        int unsigned             tail;
        int unsigned             count;
        logic [CAP_W-1:0]        capacity;
        t_deque_response         expected_responses [$];
        int                      failures;

        function new();
            capacity = CAP_W'(STORE_DEPTH);
            failures = 0;
            empty_deque();
        endfunction

        function void empty_deque();
            head  = 0;
            tail  = 0;
            count = 0;
        endfunction

        // A capacity write also empties the deque; old words stay unreachable.
        function void set_capacity(input logic [CAP_W-1:0] cap);
            capacity = cap;
            empty_deque();
        endfunction

        function int unsigned usable_capacity();
            if (capacity == 0) return 1;
            if (capacity > STORE_DEPTH) return STORE_DEPTH;
            return capacity;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Applies one accepted request to the shadow deque and queues its response.
        function void note_request(input logic [ACT_W-1:0] act,
                                   input logic signed [OUT_W-1:0] word);
            t_deque_response exp;
            int unsigned     lim;
            lim = usable_capacity();
            exp.accepted = 1'b0;
            if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
                if (count < lim) begin
                    if (count == 0) begin
                        head = 0;
                        tail = 0;
                        ring[0] = word;
                    end else if (act == ACT_PUSH_FRONT) begin
                        head = (head == 0) ? lim - 1 : head - 1;
                        ring[head] = word;
                    end else begin
                        tail = (tail + 1 >= lim) ? 0 : tail + 1;
                        ring[tail] = word;
                    end
                    count++;
                    exp.accepted = 1'b1;
                end
            end else if (act == ACT_POP_FRONT || act == ACT_POP_BACK) begin
                if (count != 0) begin
                    if (count == 1) begin
                        empty_deque();
                    end else begin
                        if (act == ACT_POP_FRONT) begin
                            head = (head + 1 >= lim) ? 0 : head + 1;
                        end else begin
                            tail = (tail == 0) ? lim - 1 : tail - 1;
                        end
                        count--;
                    end
                    exp.accepted = 1'b1;
                end
            end
            exp.front_value = (count == 0) ? -1 : ring[head];
            exp.rear_value  = (count == 0) ? -1 : ring[tail];
            exp.empty       = (count == 0);
            exp.full        = (count >= lim);
            expected_responses.push_back(exp);
        endfunction

        function void check_response(input t_deque_response got);
            t_deque_response exp;
            if (expected_responses.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: response with no request outstanding", $realtime);
                end
                return;
            end
            exp = expected_responses.pop_front();
            if (got.accepted !== exp.accepted || got.front_value !== exp.front_value ||
                    got.rear_value !== exp.rear_value || got.empty !== exp.empty ||
                    got.full !== exp.full) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: response mismatch (expected / actual)", $realtime);
                    $display("  accepted %0b / %0b  empty %0b / %0b  full %0b / %0b",
                             exp.accepted, got.accepted, exp.empty, got.empty,
                             exp.full, got.full);
                    $display("  front %0d / %0d  rear %0d / %0d",
                             exp.front_value, got.front_value,
                             exp.rear_value, got.rear_value);
                end
            end
        endfunction

        function void flag_leftovers();
            if (expected_responses.size() != 0) begin
                failures += expected_responses.size();
                $display("%0d expected responses never arrived", expected_responses.size());
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_circular_deque.sv =====
// Top-level testbench of the circular deque: stimulus, handshakes and checking.
`timescale 1ns / 100ps

module tb_circular_deque;

    import cdq_pkg::*;
    import deque_tb_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    localparam int HANG_LIMIT  = 3000;
    // Length of the deliberate response hold-off used to back up the block.
    localparam int LONG_HOLD   = 80;
    // A pop can wait on a RAM read before it answers, so this covers any work in flight.
    localparam int SETTLE      = 4;
    localparam int NUM_PHASES  = 10;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata = '0;
    logic                    i_req_valid = 1'b0;
    logic [ACT_W-1:0]        i_action    = ACT_NOP;
    logic signed [OUT_W-1:0] i_value     = '0;
    logic                    i_res_ready = 1'b0;
    logic                    o_req_ready;
    logic                    o_res_valid;
    logic                    o_accepted;
    logic signed [OUT_W-1:0] o_front_value;
    logic signed [OUT_W-1:0] o_rear_value;
    logic                    o_empty_res;
    logic                    o_full_res;

    // Knobs that the stimulus process flips between phases.
    logic req_idle_on   = 1'b1;
    logic res_idle_on   = 1'b1;
    logic long_hold_req = 1'b0;

    t_deque_scoreboard tracker = new();

    circular_deque #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (OUT_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_accepted    (o_accepted),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_empty_res   (o_empty_res),
        .o_full_res    (o_full_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Words lean on the sign boundaries and the all-zero and all-one patterns.
    function automatic logic signed [OUT_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Pushes make up push_pct percent; the spare codes show up now and then.
    function automatic logic [ACT_W-1:0] pick_action(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        end
        if (r < 94) begin
            return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
        end
        return ACT_W'($urandom_range(ACT_NOP, ACT_SPARE_7));
    endfunction

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high so that a back-to-back request keeps it up without a dip.
    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic signed [OUT_W-1:0] word);
        int gap;
        gap = req_idle_on ? idle_length() : 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_action    <= act;
        i_value     <= word;
        do begin
            @(posedge i_clk);
        end while (!o_req_ready);
        tracker.note_request(act, word);
    endtask

    // Stops offering requests and waits until every response has come back,
    // then lets the pipeline settle so the block is truly idle.
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Capacity is only ever written with the block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_capacity(cap);
    endtask

    // Response side: random stalls, plus a long hold-off on request from the
    // stimulus so that the block backs up and drops its request ready.
    initial begin : response_side
        int gap;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_res_ready <= 1'b1;
            end else begin
                gap = res_idle_on ? idle_length() : 0;
                if (gap > 0) begin
                    i_res_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_res_ready <= 1'b1;
            end
        end
    end

    // Every response taken by the testbench is checked against the oldest
    // prediction. Values are sampled before this edge's updates land.
    always @(posedge i_clk) begin : response_monitor
        t_deque_response got;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got.accepted    = o_accepted;
            got.front_value = o_front_value;
            got.rear_value  = o_rear_value;
            got.empty       = o_empty_res;
            got.full        = o_full_res;
            tracker.check_response(got);
        end
    end

    // Watchdog: counts consecutive cycles without a handshake on either side.
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        // Phases: capacity, number of requests, and whether the
        // sender and receiver idle. Small capacities swing between full and
        // empty often; the large ones exercise wrap at the top of the store.
        logic [CAP_W-1:0] phase_cap   [NUM_PHASES];
        int               phase_len   [NUM_PHASES];
        logic             phase_idle  [NUM_PHASES];
        logic             phase_hold  [NUM_PHASES];
        int               push_pct;

        phase_cap  = '{11'd2, 11'd1, 11'd3, 11'd5, 11'd16, 11'd1025, 11'd7,
                       11'd1024, 11'd2047, 11'd4};
        phase_len  = '{100, 60, 100, 120, 150, 200, 120, 100, 100, 100};
        phase_idle = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_hold = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity: pops and no-ops on an empty
        // deque, the spare action codes, extreme words at both ends, and
        // popping the last entry.
        send_request(ACT_POP_FRONT, 32'sd11);
        send_request(ACT_POP_BACK, 32'sd12);
        send_request(ACT_NOP, 32'sd13);
        send_request(ACT_SPARE_5, 32'sd14);
        send_request(ACT_SPARE_6, 32'sd15);
        send_request(ACT_PUSH_BACK, 32'sh7fff_ffff);
        send_request(ACT_PUSH_FRONT, 32'sh8000_0000);
        send_request(ACT_PUSH_BACK, '0);
        send_request(ACT_PUSH_FRONT, -32'sd1);
        send_request(ACT_SPARE_7, 32'sd16);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_POP_BACK, '0);
        send_request(ACT_PUSH_BACK, 32'sh1234_5678);

        // A capacity of zero behaves as one, and the write drops the entry
        // left in the deque above.
        write_capacity('0);
        send_request(ACT_POP_FRONT, '0);
        send_request(ACT_PUSH_BACK, 32'sd5);
        send_request(ACT_PUSH_FRONT, 32'sd6);
        send_request(ACT_POP_FRONT, '0);

        // Capacity above the store depth: a front push from a single entry
        // wraps the head to the last slot, and a back pop follows it there.
        write_capacity('1);
        send_request(ACT_PUSH_BACK, 32'sd21);
        send_request(ACT_PUSH_FRONT, 32'sd22);
        send_request(ACT_POP_BACK, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            req_idle_on = phase_idle[p];
            res_idle_on = phase_idle[p];
            // The hold-off phases run the sender flat out so the block fills.
            if (phase_hold[p]) begin
                req_idle_on   = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < phase_len[p]; n++) begin
                // Alternate push-heavy and pop-heavy stretches so the deque
                // keeps climbing to full and falling back to empty.
                push_pct = ((n / 20) % 2 == 0) ? 70 : 25;
                if (phase_cap[p] > STORE_DEPTH / 2) begin
                    push_pct = 80;
                end
                send_request(pick_action(push_pct), pick_word());
            end
        end

        drain_responses();
        tracker.flag_leftovers();
        if (tracker.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
